// File: src/lrc_pkg.sv
package lrc_pkg;

  localparam int unsigned CW              = 32;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned MAG_W           = CW + 1;
  localparam int unsigned DIV_W           = CW + COORD_FRAC_BITS;
  localparam int unsigned RA_W            = COORD_FRAC_BITS + 1;
  localparam int unsigned PA_W            = RA_W + MAG_W;
  localparam int unsigned PBL_W           = CW + MAG_W;
  localparam int unsigned PBH_W           = DIV_W - CW + MAG_W;
  localparam int unsigned PB_W            = DIV_W + MAG_W;
  localparam int unsigned CAP_W           = 63;
  localparam int unsigned TERM_W          = CAP_W - COORD_FRAC_BITS;
  localparam int unsigned SUM_W           = TERM_W + 2;

  typedef logic signed [CW-1:0]    coord_t;
  typedef logic signed [CW:0]      diff_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [CAP_W-1:0]        cap_t;

  localparam cap_t PROD_CAP = cap_t'(1) << (CAP_W - 1);

  typedef enum logic [1:0] {
    CFG_X_MIN = 2'd0,
    CFG_X_MAX = 2'd1,
    CFG_Y_MIN = 2'd2,
    CFG_Y_MAX = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    coord_t x_min;
    coord_t x_max;
    coord_t y_min;
    coord_t y_max;
  } win_t;

  typedef struct packed {
    logic       reject;
    logic       vis;
    logic       axes;
    logic       ends;
    logic       dy_neg;
    logic       dy_zero;
    logic       dx_zero;
    logic [2:0] neg;
    coord_t     x1;
    coord_t     y1;
    coord_t     x2;
    coord_t     y2;
  } item_t;

  typedef struct packed {
    item_t it;
    mag_t  m1;
    mag_t  m2;
    mag_t  m3;
  } dpay_t;

  typedef struct packed {
    item_t             it;
    logic [RA_W-1:0]   ra;
    logic [DIV_W-1:0]  rb;
  } post_t;

  typedef struct packed {
    logic   visible;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } res_t;

  function automatic win_t work_win(logic axes, win_t w);
    win_t r;
    r = w;
    if (axes) begin
      r.x_min = w.y_min;
      r.x_max = w.y_max;
      r.y_min = w.x_min;
      r.y_max = w.x_max;
    end
    return r;
  endfunction

  function automatic diff_t coord_diff(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic mag_t diff_mag(diff_t d);
    diff_t n;
    n = -d;
    return d[CW] ? mag_t'(n) : mag_t'(d);
  endfunction

  function automatic cap_t cap_prod(logic [PB_W-1:0] p);
    if (p > PB_W'(PROD_CAP)) begin
      return PROD_CAP;
    end
    return p[CAP_W-1:0];
  endfunction

  function automatic sum_t along_sum(coord_t base, cap_t prod, logic neg, logic zero);
    logic [TERM_W-1:0] term;
    sum_t b;
    sum_t t;
    term = zero ? '0 : prod[CAP_W-1:COORD_FRAC_BITS];
    b    = sum_t'(base);
    t    = sum_t'({2'b00, term});
    return neg ? b - t : b + t;
  endfunction

  function automatic coord_t clamp_coord(sum_t s);
    if (s[SUM_W-1:CW-1] == '0 || s[SUM_W-1:CW-1] == '1) begin
      return s[CW-1:0];
    end
    if (s[SUM_W-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return {1'b0, {(CW-1){1'b1}}};
  endfunction

endpackage

// File: src/lrc_div.sv
module lrc_div import lrc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [CW-1:0]    den_i,
  output logic [DIV_W-1:0] quo_o
);

  typedef struct packed {
    logic [CW-1:0]    rem;
    logic [DIV_W-1:0] num;
    logic [CW-1:0]    den;
    logic [DIV_W-1:0] quo;
  } dstg_t;

  dstg_t stg_q [DIV_W];
  dstg_t stg_d [DIV_W];

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < DIV_W; k++) begin : g_stg
    dstg_t         cur;
    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          ge;
    if (k == 0) begin : g_first
      assign cur = '{rem: '0, num: num_i, den: den_i, quo: '0};
    end else begin : g_next
      assign cur = stg_q[k-1];
    end
    assign trial    = {cur.rem, cur.num[DIV_W-1]};
    assign diff     = trial - {1'b0, cur.den};
    assign ge       = trial >= {1'b0, cur.den};
    assign stg_d[k] = '{rem: ge ? diff[CW-1:0] : trial[CW-1:0],
                        num: {cur.num[DIV_W-2:0], 1'b0},
                        den: cur.den,
                        quo: {cur.quo[DIV_W-2:0], ge}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q <= stg_d;
    end
  end

  assign quo_o = stg_q[DIV_W-1].quo;

endmodule

// File: src/line_rectangle_clip.sv
// Throughput: one segment per cycle while the skid entry is empty (in_ready_o is low
// otherwise); the depth is set by the two 48-stage slope dividers (one quotient bit
// per stage) plus two multiply/sum rounds.
// A two-entry output buffer (output register plus skid) decouples the sides.
// Reset clears all valid bits and sets the four window registers to zero.
module line_rectangle_clip import lrc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [CW-1:0] cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  coord_t        start_x_i,
  input  coord_t        start_y_i,
  input  coord_t        end_x_i,
  input  coord_t        end_y_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          visible_o,
  output coord_t        clipped_start_x_o,
  output coord_t        clipped_start_y_o,
  output coord_t        clipped_end_x_o,
  output coord_t        clipped_end_y_o
);

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    diff_t  dx;
    diff_t  dy;
    logic   reject;
  } s1_t;

  typedef struct packed {
    coord_t        x1;
    coord_t        y1;
    coord_t        x2;
    coord_t        y2;
    logic [CW-1:0] dx;
    diff_t         dy;
    logic          axes;
    logic          ends;
    logic          reject;
  } s2_t;

  win_t win_q;
  logic adv;

  // ---------------- window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_MIN: win_q.x_min <= cfg_data_i;
        CFG_X_MAX: win_q.x_max <= cfg_data_i;
        CFG_Y_MIN: win_q.y_min <= cfg_data_i;
        CFG_Y_MAX: win_q.y_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: trivial reject, differences
  s1_t s1_d, s1_q;

  always_comb begin
    s1_d.x1 = start_x_i;
    s1_d.y1 = start_y_i;
    s1_d.x2 = end_x_i;
    s1_d.y2 = end_y_i;
    s1_d.dx = coord_diff(end_x_i, start_x_i);
    s1_d.dy = coord_diff(end_y_i, start_y_i);
    s1_d.reject = (start_x_i < win_q.x_min && end_x_i < win_q.x_min) ||
                  (start_x_i > win_q.x_max && end_x_i > win_q.x_max) ||
                  (start_y_i < win_q.y_min && end_y_i < win_q.y_min) ||
                  (start_y_i > win_q.y_max && end_y_i > win_q.y_max);
  end

  // ---------------- stage 2: axis swap, endpoint order
  s2_t   s2_d, s2_q;
  mag_t  s2_adx, s2_ady;
  diff_t s2_dxa, s2_dya, s2_dxn;

  always_comb begin
    s2_adx      = diff_mag(s1_q.dx);
    s2_ady      = diff_mag(s1_q.dy);
    s2_d.axes   = s2_adx < s2_ady;
    s2_d.reject = s1_q.reject;
    s2_dxa      = s2_d.axes ? s1_q.dy : s1_q.dx;
    s2_dya      = s2_d.axes ? s1_q.dx : s1_q.dy;
    s2_d.ends   = s2_dxa[CW];
    if (s2_d.axes) begin
      s2_d.x1 = s1_q.y1;
      s2_d.y1 = s1_q.x1;
      s2_d.x2 = s1_q.y2;
      s2_d.y2 = s1_q.x2;
    end else begin
      s2_d.x1 = s1_q.x1;
      s2_d.y1 = s1_q.y1;
      s2_d.x2 = s1_q.x2;
      s2_d.y2 = s1_q.y2;
    end
    if (s2_d.ends) begin
      s2_d.x1 = s2_d.x2;
      s2_d.y1 = s2_d.y2;
      s2_d.x2 = s2_d.axes ? s1_q.y1 : s1_q.x1;
      s2_d.y2 = s2_d.axes ? s1_q.x1 : s1_q.y1;
      s2_dxn  = -s2_dxa;
      s2_d.dy = -s2_dya;
    end else begin
      s2_dxn  = s2_dxa;
      s2_d.dy = s2_dya;
    end
    s2_d.dx = s2_dxn[CW-1:0];
  end

  // ---------------- stage 3: first-round deltas, divider operands
  dpay_t         s3_d, s3_q;
  logic [CW-1:0] s3_ady_d, s3_ady_q, s3_dx_q;
  win_t          s3_w;
  mag_t          s3_ady_full;
  diff_t         s3_d1, s3_d2, s3_d3;
  logic          s3_dy_pos;

  always_comb begin
    s3_w        = work_win(s2_q.axes, win_q);
    s3_ady_full = diff_mag(s2_q.dy);
    s3_ady_d    = s3_ady_full[CW-1:0];
    s3_dy_pos   = !s2_q.dy[CW] && s2_q.dy != '0;
    s3_d1       = coord_diff(s3_w.x_min, s2_q.x2);
    s3_d2       = coord_diff(s3_w.x_max, s2_q.x2);
    s3_d3       = coord_diff(s3_dy_pos ? s3_w.y_min : s3_w.y_max, s2_q.y2);
    s3_d.it.reject  = s2_q.reject;
    s3_d.it.vis     = !s2_q.reject;
    s3_d.it.axes    = s2_q.axes;
    s3_d.it.ends    = s2_q.ends;
    s3_d.it.dy_neg  = s2_q.dy[CW];
    s3_d.it.dy_zero = s2_q.dy == '0;
    s3_d.it.dx_zero = s2_q.dx == '0;
    s3_d.it.neg     = {s2_q.dy[CW] ^ s3_d3[CW], s2_q.dy[CW] ^ s3_d2[CW],
                       s2_q.dy[CW] ^ s3_d1[CW]};
    s3_d.it.x1      = s2_q.x1;
    s3_d.it.y1      = s2_q.y1;
    s3_d.it.x2      = s2_q.x2;
    s3_d.it.y2      = s2_q.y2;
    s3_d.m1         = diff_mag(s3_d1);
    s3_d.m2         = diff_mag(s3_d2);
    s3_d.m3         = diff_mag(s3_d3);
  end

  // ---------------- slope dividers
  logic [DIV_W-1:0] quo_a, quo_b;

  lrc_div u_div_a (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({s3_ady_q, {COORD_FRAC_BITS{1'b0}}}),
    .den_i (s3_dx_q),
    .quo_o (quo_a)
  );

  lrc_div u_div_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({s3_dx_q, {COORD_FRAC_BITS{1'b0}}}),
    .den_i (s3_ady_q),
    .quo_o (quo_b)
  );

  dpay_t dl_q [DIV_W];

  // ---------------- M2: first-round products
  post_t            m2_d, m2_q;
  logic [PA_W-1:0]  m2_pa1_d, m2_pa1_q, m2_pa2_d, m2_pa2_q;
  logic [PBL_W-1:0] m2_pbl_d, m2_pbl_q;
  logic [PBH_W-1:0] m2_pbh_d, m2_pbh_q;

  always_comb begin
    m2_d.it  = dl_q[DIV_W-1].it;
    m2_d.ra  = quo_a[RA_W-1:0];
    m2_d.rb  = quo_b;
    m2_pa1_d = PA_W'(m2_d.ra) * PA_W'(dl_q[DIV_W-1].m1);
    m2_pa2_d = PA_W'(m2_d.ra) * PA_W'(dl_q[DIV_W-1].m2);
    m2_pbl_d = PBL_W'(quo_b[CW-1:0]) * PBL_W'(dl_q[DIV_W-1].m3);
    m2_pbh_d = PBH_W'(quo_b[DIV_W-1:CW]) * PBH_W'(dl_q[DIV_W-1].m3);
  end

  // ---------------- M3: saturate products
  post_t m3_q;
  cap_t  m3_ca1_q, m3_ca2_q, m3_cb_q;

  // ---------------- M4: sums
  post_t m4_q;
  sum_t  m4_y1c_q, m4_yr_q, m4_x1c_q;

  // ---------------- F: first endpoint
  post_t f_d, f_q;
  win_t  f_w;
  logic  f_dy_pos;

  always_comb begin
    f_d      = m4_q;
    f_w      = work_win(m4_q.it.axes, win_q);
    f_dy_pos = !m4_q.it.dy_neg && !m4_q.it.dy_zero;
    if (m4_q.it.x1 < f_w.x_min) begin
      f_d.it.x1 = f_w.x_min;
      f_d.it.y1 = clamp_coord(m4_y1c_q);
    end
    if (f_dy_pos) begin
      if (f_d.it.y1 > f_w.y_max) begin
        f_d.it.vis = 1'b0;
      end else if (f_d.it.y1 < f_w.y_min) begin
        if (m4_yr_q < sum_t'(f_w.y_min)) begin
          f_d.it.vis = 1'b0;
        end else begin
          f_d.it.y1 = f_w.y_min;
          f_d.it.x1 = clamp_coord(m4_x1c_q);
        end
      end
    end else begin
      if (f_d.it.y1 < f_w.y_min) begin
        f_d.it.vis = 1'b0;
      end else if (f_d.it.y1 > f_w.y_max) begin
        if (m4_yr_q > sum_t'(f_w.y_max)) begin
          f_d.it.vis = 1'b0;
        end else begin
          f_d.it.y1 = f_w.y_max;
          f_d.it.x1 = clamp_coord(m4_x1c_q);
        end
      end
    end
  end

  // ---------------- F2: second-round deltas
  post_t f2_d, f2_q;
  mag_t  f2_m4_d, f2_m4_q, f2_m5_d, f2_m5_q;
  win_t  f2_w;
  diff_t f2_d4, f2_d5;

  always_comb begin
    f2_d    = f_q;
    f2_w    = work_win(f_q.it.axes, win_q);
    f2_d4   = coord_diff(f2_w.x_max, f_q.it.x1);
    f2_d5   = coord_diff(f_q.it.dy_neg ? f2_w.y_min : f2_w.y_max, f_q.it.y1);
    f2_d.it.neg = {f_q.it.dy_neg ^ f2_d5[CW], 1'b0, f_q.it.dy_neg ^ f2_d4[CW]};
    f2_m4_d = diff_mag(f2_d4);
    f2_m5_d = diff_mag(f2_d5);
  end

  // ---------------- M5..M7: second-round products and sums
  item_t            m5_q, m6_q, m7_q;
  logic [PA_W-1:0]  m5_pa_q;
  logic [PBL_W-1:0] m5_pbl_q;
  logic [PBH_W-1:0] m5_pbh_q;
  cap_t             m6_ca_q, m6_cb_q;
  sum_t             m7_y2c_q, m7_x2c_q;

  // ---------------- G: second endpoint, restore order and axes
  res_t   g_d, g_q;
  win_t   g_w;
  coord_t g_x1, g_y1, g_x2, g_y2;

  always_comb begin
    g_w  = work_win(m7_q.axes, win_q);
    g_x1 = m7_q.x1;
    g_y1 = m7_q.y1;
    g_x2 = m7_q.x2;
    g_y2 = m7_q.y2;
    if (g_x2 > g_w.x_max) begin
      g_x2 = g_w.x_max;
      g_y2 = clamp_coord(m7_y2c_q);
    end
    if (m7_q.dy_neg) begin
      if (g_y2 < g_w.y_min) begin
        g_y2 = g_w.y_min;
        g_x2 = clamp_coord(m7_x2c_q);
      end
    end else if (g_y2 > g_w.y_max) begin
      g_y2 = g_w.y_max;
      g_x2 = clamp_coord(m7_x2c_q);
    end
    g_d.visible = m7_q.vis;
    g_d.x1 = m7_q.ends ? g_x2 : g_x1;
    g_d.y1 = m7_q.ends ? g_y2 : g_y1;
    g_d.x2 = m7_q.ends ? g_x1 : g_x2;
    g_d.y2 = m7_q.ends ? g_y1 : g_y2;
    if (m7_q.axes) begin
      g_d.x1 = m7_q.ends ? g_y2 : g_y1;
      g_d.y1 = m7_q.ends ? g_x2 : g_x1;
      g_d.x2 = m7_q.ends ? g_y1 : g_y2;
      g_d.y2 = m7_q.ends ? g_x1 : g_x2;
    end
    if (!m7_q.vis) begin
      g_d.x1 = '0;
      g_d.y1 = '0;
      g_d.x2 = '0;
      g_d.y2 = '0;
    end
  end

  // ---------------- pipeline data registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      s3_q     <= s3_d;
      s3_ady_q <= s3_ady_d;
      s3_dx_q  <= s2_q.dx;
      dl_q[0]  <= s3_q;
      for (int k = 1; k < DIV_W; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
      m2_q     <= m2_d;
      m2_pa1_q <= m2_pa1_d;
      m2_pa2_q <= m2_pa2_d;
      m2_pbl_q <= m2_pbl_d;
      m2_pbh_q <= m2_pbh_d;
      m3_q     <= m2_q;
      m3_ca1_q <= cap_prod(PB_W'(m2_pa1_q));
      m3_ca2_q <= cap_prod(PB_W'(m2_pa2_q));
      m3_cb_q  <= cap_prod({m2_pbh_q, {CW{1'b0}}} + PB_W'(m2_pbl_q));
      m4_q     <= m3_q;
      m4_y1c_q <= along_sum(m3_q.it.y2, m3_ca1_q, m3_q.it.neg[0], m3_q.it.dx_zero);
      m4_yr_q  <= along_sum(m3_q.it.y2, m3_ca2_q, m3_q.it.neg[1], m3_q.it.dx_zero);
      m4_x1c_q <= along_sum(m3_q.it.x2, m3_cb_q, m3_q.it.neg[2], m3_q.it.dy_zero);
      f_q      <= f_d;
      f2_q     <= f2_d;
      f2_m4_q  <= f2_m4_d;
      f2_m5_q  <= f2_m5_d;
      m5_q     <= f2_q.it;
      m5_pa_q  <= PA_W'(f2_q.ra) * PA_W'(f2_m4_q);
      m5_pbl_q <= PBL_W'(f2_q.rb[CW-1:0]) * PBL_W'(f2_m5_q);
      m5_pbh_q <= PBH_W'(f2_q.rb[DIV_W-1:CW]) * PBH_W'(f2_m5_q);
      m6_q     <= m5_q;
      m6_ca_q  <= cap_prod(PB_W'(m5_pa_q));
      m6_cb_q  <= cap_prod({m5_pbh_q, {CW{1'b0}}} + PB_W'(m5_pbl_q));
      m7_q     <= m6_q;
      m7_y2c_q <= along_sum(m6_q.y1, m6_ca_q, m6_q.neg[0], m6_q.dx_zero);
      m7_x2c_q <= along_sum(m6_q.x1, m6_cb_q, m6_q.neg[2], m6_q.dy_zero);
      g_q      <= g_d;
    end
  end

  // ---------------- valid bits
  logic             s1_v_q, s2_v_q, s3_v_q;
  logic [DIV_W-1:0] dl_v_q;
  logic             m2_v_q, m3_v_q, m4_v_q, f_v_q, f2_v_q;
  logic             m5_v_q, m6_v_q, m7_v_q, g_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      dl_v_q <= '0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
      f_v_q  <= 1'b0;
      f2_v_q <= 1'b0;
      m5_v_q <= 1'b0;
      m6_v_q <= 1'b0;
      m7_v_q <= 1'b0;
      g_v_q  <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      dl_v_q <= {dl_v_q[DIV_W-2:0], s3_v_q};
      m2_v_q <= dl_v_q[DIV_W-1];
      m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q;
      f_v_q  <= m4_v_q;
      f2_v_q <= f_v_q;
      m5_v_q <= f2_v_q;
      m6_v_q <= m5_v_q;
      m7_v_q <= m6_v_q;
      g_v_q  <= m7_v_q;
    end
  end

  // ---------------- output register with skid
  res_t out_q, skid_q;
  logic out_v_d, out_v_q, skid_v_d, skid_v_q;
  logic out_take, load_out, load_skid;

  assign adv        = !skid_v_q;
  assign in_ready_o = adv;
  assign out_take   = out_v_q && out_ready_i;

  always_comb begin
    out_v_d   = out_v_q;
    skid_v_d  = skid_v_q;
    load_out  = 1'b0;
    load_skid = 1'b0;
    if (skid_v_q) begin
      if (out_take) begin
        load_out = 1'b1;
        skid_v_d = 1'b0;
      end
    end else if (g_v_q) begin
      if (!out_v_q || out_take) begin
        load_out = 1'b1;
        out_v_d  = 1'b1;
      end else begin
        load_skid = 1'b1;
        skid_v_d  = 1'b1;
      end
    end else if (out_take) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_v_q ? skid_q : g_q;
    end
    if (load_skid) begin
      skid_q <= g_q;
    end
  end

  assign out_valid_o       = out_v_q;
  assign visible_o         = out_q.visible;
  assign clipped_start_x_o = out_q.x1;
  assign clipped_start_y_o = out_q.y1;
  assign clipped_end_x_o   = out_q.x2;
  assign clipped_end_y_o   = out_q.y2;

endmodule

// File: tb/line_rectangle_clip_checker.sv
module line_rectangle_clip_checker import lrc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [CW-1:0] cfg_data_i,
  input  logic   in_valid_i,
  input  logic   in_ready_i,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  input  logic   out_valid_i,
  input  logic   out_ready_i,
  input  logic   visible_i,
  input  coord_t clipped_start_x_i,
  input  coord_t clipped_start_y_i,
  input  coord_t clipped_end_x_i,
  input  coord_t clipped_end_y_i,
  output int     fail_count_o,
  output int     pending_o,
  output int     visible_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        vis;
    longint      x1;
    longint      y1;
    longint      x2;
    longint      y2;
  } clip_t;

  longint win_xmin, win_xmax, win_ymin, win_ymax;
  clip_t  clip_queue[$];
  int     fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = clip_queue.size();

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // base + num/den*delta with Q16 ratio, product capped at 2^62
  function automatic longint slope_point(longint base, longint num, longint den,
                                         longint delta);
    logic [63:0]  r, ad;
    logic [127:0] p;
    logic         neg;
    if (den == 0) return base;
    r  = (64'(abs64(num)) << COORD_FRAC_BITS) / 64'(abs64(den));
    ad = 64'(abs64(delta));
    p  = 128'(r) * 128'(ad);
    if (p > 128'(PROD_CAP)) p = 128'(PROD_CAP);
    p  = p >> COORD_FRAC_BITS;
    neg = ((num < 0) != (den < 0)) != (delta < 0);
    return neg ? base - longint'(p[63:0]) : base + longint'(p[63:0]);
  endfunction

  function automatic clip_t clip_segment(longint ax, longint ay, longint bx, longint by);
    clip_t  c;
    longint x1, y1, x2, y2, xmin, xmax, ymin, ymax, dx, dy, t;
    logic   axes, ends;
    x1 = ax; y1 = ay; x2 = bx; y2 = by;
    xmin = win_xmin; xmax = win_xmax; ymin = win_ymin; ymax = win_ymax;
    c = '{1'b0, 0, 0, 0, 0};
    axes = 0; ends = 0;
    if ((x1 < xmin && x2 < xmin) || (x1 > xmax && x2 > xmax) ||
        (y1 < ymin && y2 < ymin) || (y1 > ymax && y2 > ymax)) return c;
    dx = x2 - x1;
    dy = y2 - y1;
    if (abs64(dx) < abs64(dy)) begin
      axes = 1;
      t = x1; x1 = y1; y1 = t;
      t = x2; x2 = y2; y2 = t;
      t = xmin; xmin = ymin; ymin = t;
      t = xmax; xmax = ymax; ymax = t;
      t = dx; dx = dy; dy = t;
    end
    if (dx < 0) begin
      ends = 1;
      t = x1; x1 = x2; x2 = t;
      t = y1; y1 = y2; y2 = t;
      dx = -dx; dy = -dy;
    end
    if (x1 < xmin) begin
      x1 = xmin;
      y1 = sat32(slope_point(y2, dy, dx, xmin - x2));
    end
    if (dy > 0) begin
      if (y1 > ymax) return c;
      if (y1 < ymin) begin
        if (slope_point(y2, dy, dx, xmax - x2) < ymin) return c;
        y1 = ymin;
        x1 = sat32(slope_point(x2, dx, dy, ymin - y2));
      end
    end else begin
      if (y1 < ymin) return c;
      if (y1 > ymax) begin
        if (slope_point(y2, dy, dx, xmax - x2) > ymax) return c;
        y1 = ymax;
        x1 = sat32(slope_point(x2, dx, dy, ymax - y2));
      end
    end
    if (x2 > xmax) begin
      x2 = xmax;
      y2 = sat32(slope_point(y1, dy, dx, xmax - x1));
    end
    if (dy < 0) begin
      if (y2 < ymin) begin
        y2 = ymin;
        x2 = sat32(slope_point(x1, dx, dy, ymin - y1));
      end
    end else if (y2 > ymax) begin
      y2 = ymax;
      x2 = sat32(slope_point(x1, dx, dy, ymax - y1));
    end
    if (ends) begin
      t = x1; x1 = x2; x2 = t;
      t = y1; y1 = y2; y2 = t;
    end
    if (axes) begin
      t = x1; x1 = y1; y1 = t;
      t = x2; x2 = y2; y2 = t;
    end
    c = '{1'b1, x1, y1, x2, y2};
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    clip_t  e;
    coord_t got_x1, got_y1, got_x2, got_y2;
    if (!rst_ni) begin
      win_xmin <= 0; win_xmax <= 0; win_ymin <= 0; win_ymax <= 0;
      clip_queue.delete();
      fail_count <= 0;
      visible_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_X_MIN: win_xmin <= longint'($signed(cfg_data_i));
          CFG_X_MAX: win_xmax <= longint'($signed(cfg_data_i));
          CFG_Y_MIN: win_ymin <= longint'($signed(cfg_data_i));
          CFG_Y_MAX: win_ymax <= longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        clip_queue.push_back(clip_segment(start_x_i, start_y_i, end_x_i, end_y_i));
      if (out_valid_i && out_ready_i) begin
        if (visible_i) visible_count_o <= visible_count_o + 1;
        if (clip_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          e = clip_queue.pop_front();
          got_x1 = coord_t'(e.x1); got_y1 = coord_t'(e.y1);
          got_x2 = coord_t'(e.x2); got_y2 = coord_t'(e.y2);
          if (visible_i !== e.vis || clipped_start_x_i !== got_x1 ||
              clipped_start_y_i !== got_y1 || clipped_end_x_i !== got_x2 ||
              clipped_end_y_i !== got_y2) begin
            if (fail_count < 10)
              $display("mismatch: exp %0b %0d %0d %0d %0d got %0b %0d %0d %0d %0d",
                       e.vis, got_x1, got_y1, got_x2, got_y2, visible_i,
                       clipped_start_x_i, clipped_start_y_i, clipped_end_x_i,
                       clipped_end_y_i);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/line_rectangle_clip_test.sv
module line_rectangle_clip_test;
  import lrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk_i = 0, rst_ni = 0;
  logic          cfg_we_i = 0;
  logic [1:0]    cfg_idx_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic          in_valid_i = 0, in_ready_o;
  coord_t        start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic          out_valid_o, out_ready_i = 0, visible_o;
  coord_t        clipped_start_x_o, clipped_start_y_o, clipped_end_x_o, clipped_end_y_o;
  int            fail_count, pending, visible_count;
  int            idle_cycles = 0, segments_sent = 0;
  logic          hold_off = 0, stimulus_done = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  line_rectangle_clip dut (.*);

  line_rectangle_clip_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .visible_i(visible_o),
    .clipped_start_x_i(clipped_start_x_o), .clipped_start_y_i(clipped_start_y_o),
    .clipped_end_x_i(clipped_end_x_o), .clipped_end_y_i(clipped_end_y_o),
    .fail_count_o(fail_count), .pending_o(pending), .visible_count_o(visible_count)
  );

  // receiver: random stalls, calm stretches, and one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 0;
    else if (segments_sent % 300 < 60) out_ready_i <= 1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    @(posedge clk_i);
    wait (segments_sent >= 200);
    @(posedge clk_i);
    hold_off = 1;
    repeat (150) @(posedge clk_i);
    hold_off = 0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL line_rectangle_clip");
      $finish;
    end
  end

  function automatic coord_t rand_coord(int mode, coord_t lo, coord_t hi);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 7) == 0 ? 32'h8000_0000 : 32'h7fff_ffff);
      default: return lo + coord_t'($urandom_range(0, 32'(hi - lo) + 32'h20000)) - 32'h10000;
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, coord_t v);
    @(posedge clk_i);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 0;
  endtask

  task automatic set_window(coord_t xl, coord_t xh, coord_t yl, coord_t yh);
    write_reg(CFG_X_MIN, xl);
    write_reg(CFG_X_MAX, xh);
    write_reg(CFG_Y_MIN, yl);
    write_reg(CFG_Y_MAX, yh);
  endtask

  task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    in_valid_i <= 1;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    do @(posedge clk_i); while (!in_ready_o);
    segments_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic random_phase(int count, coord_t xl, coord_t xh, coord_t yl, coord_t yh);
    int burst, mode, mx, my;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) == 0) begin
          in_valid_i <= 0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
      burst--;
      mode = $urandom_range(0, 9);
      mx = (mode == 0) ? 0 : (mode == 1 ? 1 : 2);
      my = (mode == 2) ? 1 : mx;
      send_segment(rand_coord(mx, xl, xh), rand_coord(my, yl, yh),
                   rand_coord(mx, xl, xh), rand_coord(my, yl, yh));
    end
  endtask

  initial begin
    coord_t cmin, cmax;
    cmin = 32'sh8000_0000;
    cmax = 32'sh7fff_ffff;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    set_window(-32'sh0010_0000, 32'sh0010_0000, -32'sh0008_0000, 32'sh0008_0000);
    send_segment(-32'sh0020_0000, 0, 32'sh0020_0000, 0);
    send_segment(0, -32'sh0020_0000, 32'sh0001_0000, 32'sh0020_0000);
    send_segment(32'sh0020_0000, 32'sh0001_0000, -32'sh0020_0000, -32'sh0003_0000);
    send_segment(-32'sh0030_0000, 0, -32'sh0020_0000, 0);
    send_segment(32'sh0030_0000, 0, 32'sh0020_0000, 5);
    send_segment(0, -32'sh0030_0000, 3, -32'sh0020_0000);
    send_segment(0, 32'sh0030_0000, 3, 32'sh0020_0000);
    send_segment(5, 7, 5, 7);
    send_segment(32'sh0040_0000, 7, 32'sh0040_0000, 7);
    send_segment(cmin, cmin, cmax, cmax);
    send_segment(cmax, cmin, cmin, cmax);
    send_segment(cmin, 0, cmax, 1);
    send_segment(-32'sh0020_0000, -32'sh0009_0000, 32'sh0020_0000, -32'sh0007_0000);
    send_segment(-32'sh0020_0000, 32'sh0009_0000, 32'sh0020_0000, 32'sh000a_0000);
    send_segment(32'sh0010_0000, 32'sh0008_0000, -32'sh0010_0000, -32'sh0008_0000);
    send_segment(-32'sh0011_0000, 32'sh0009_0000, 32'sh0001_0000, -32'sh0009_0000);
    drain();
    set_window(cmin, cmax, cmin, cmax);
    send_segment(cmin, cmax, cmax, cmin);
    send_segment(cmax, 0, cmin, -1);
    random_phase(150, -32'sh0100_0000, 32'sh0100_0000, -32'sh0100_0000, 32'sh0100_0000);
    drain();
    set_window(-32'sh0040_0000, 32'sh0080_0000, -32'sh0020_0000, 32'sh0060_0000);
    random_phase(350, -32'sh0040_0000, 32'sh0080_0000, -32'sh0020_0000, 32'sh0060_0000);
    drain();
    set_window(32'sh0010_0000, -32'sh0010_0000, 32'sh0005_0000, -32'sh0005_0000);
    random_phase(80, -32'sh0010_0000, 32'sh0010_0000, -32'sh0005_0000, 32'sh0005_0000);
    drain();
    set_window(0, 32'sh0000_0100, cmax - 32'sh100, cmax);
    random_phase(80, 0, 32'sh0000_0100, cmax - 32'sh1_0000, cmax - 32'sh1_0000);
    drain();
    set_window(-32'sh2000_0000, 32'sh3000_0000, -32'sh1000_0000, 32'sh1000_0000);
    random_phase(270, -32'sh2000_0000, 32'sh3000_0000, -32'sh1000_0000, 32'sh1000_0000);
    drain();
    stimulus_done = 1;
    $display("sent %0d segments over six windows, %0d came back visible",
             segments_sent, visible_count);
    if (fail_count == 0) $display("PASS line_rectangle_clip");
    else $display("FAIL line_rectangle_clip");
    $finish;
  end
endmodule

// File: files.f
src/lrc_pkg.sv
src/lrc_div.sv
src/line_rectangle_clip.sv
tb/line_rectangle_clip_checker.sv
tb/line_rectangle_clip_test.sv
